// ===== rtl/bal_pkg.sv =====
// Package for the bounded array list engine.
// Holds operation and status codes, the request and result types and fixed limits.
// No dependencies.
package bal_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned MAX_RESULTS = 32;

  // Operation codes carried in the func field.
  localparam logic [3:0] F_CLEAR    = 4'd0;
  localparam logic [3:0] F_APPEND   = 4'd1;
  localparam logic [3:0] F_READ     = 4'd2;
  localparam logic [3:0] F_UPDATE   = 4'd3;
  localparam logic [3:0] F_DELETE   = 4'd4;
  localparam logic [3:0] F_INSERT   = 4'd5;
  localparam logic [3:0] F_SORT     = 4'd6;
  localparam logic [3:0] F_CONTAINS = 4'd7;
  localparam logic [3:0] F_POSNS    = 4'd8;
  localparam logic [3:0] F_COUNT    = 4'd9;
  localparam logic [3:0] F_MAX      = 4'd10;
  localparam logic [3:0] F_MIN      = 4'd11;
  localparam logic [3:0] F_SIZE     = 4'd12;
  localparam logic [3:0] F_LIST     = 4'd13;
  localparam logic [3:0] F_REVERSE  = 4'd14;
  localparam logic [3:0] F_NOP      = 4'd15;

  // Status codes of a result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]               func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         where;
    logic [POS_W-1:0]         tally;
    logic                     last;
  } rsp_t;

endpackage

// ===== rtl/bal_chan_if.sv =====
// Valid/ready channel carrying one request or result per handshake.
// The payload type is given by the instantiating code, normally from bal_pkg.
interface bal_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bal_mem.sv =====
// Element store of the list: one write port and one read port with registered data.
// Depends on bal_pkg for the element width.
module bal_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              wa,
  input  logic [bal_pkg::DATA_W-1:0] wd,
  input  logic                       re,
  input  logic [AW-1:0]              ra,
  output logic [bal_pkg::DATA_W-1:0] rq
);
  import bal_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rq <= mem_r[ra];
    end
  end
endmodule

// ===== rtl/bounded_array_list_engine_core.sv =====
// Channel    Dir  Payload                                Handshake
// in_ch      in   func, position, value                  valid/ready
// out_ch     out  status, data, where, tally, last       valid/ready
//
// One request at a time. Shifts, scans and listings walk the elements one by one,
// as every step goes through the single read port of the element memory.
// Reset clears the fill count and the sequencer; the element memory is not cleared.
// A stalled result channel holds the sequencer; new requests wait for idle.
// Top level of the bounded array list engine; uses bal_pkg, bal_chan_if and bal_mem.
module bounded_array_list_engine_core #(
  parameter int unsigned CAPACITY = 32
) (
  input logic clk,
  input logic rst_n,
  bal_chan_if.sink   in_ch,
  bal_chan_if.source out_ch
);
  import bal_pkg::*;

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = ((FW > POS_W) ? FW : POS_W) + 1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RDP  = 14'b00000000000010,
    S_INS  = 14'b00000000000100,
    S_INSW = 14'b00000000001000,
    S_DEL  = 14'b00000000010000,
    S_DELW = 14'b00000000100000,
    S_SRT0 = 14'b00000001000000,
    S_SRTC = 14'b00000010000000,
    S_SRTR = 14'b00000100000000,
    S_SRTE = 14'b00001000000000,
    S_SRTX = 14'b00010000000000,
    S_SCR  = 14'b00100000000000,
    S_SCE  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [3:0]           op_r, op_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [DATA_W-1:0]    val_r, val_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    best_r, best_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [POS_W-1:0]     pend_w_r, pend_w_nxt;
  rsp_t                 res_r, res_nxt;
  rsp_t                 out_r;
  logic                 out_valid_r;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [DATA_W-1:0]    mem_wd, mem_q;

  logic                 can_emit, emit;
  rsp_t                 em;
  logic [CW-1:0]        posx, list_n, c_inc;
  logic                 hit, at_end, better, stop;

  bal_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .wa(mem_wa), .wd(mem_wd),
    .re(mem_re), .ra(mem_ra), .rq(mem_q)
  );

  assign can_emit     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_r;

  assign posx   = CW'(in_ch.payload.position);
  assign list_n = (fill_r < CW'(MAX_RESULTS)) ? fill_r : CW'(MAX_RESULTS);
  assign hit    = (mem_q == val_r);
  assign at_end = (idx_r + CW'(1)) == fill_r;
  assign better = (op_r == F_MAX) ? ($signed(mem_q) > $signed(best_r))
                                  : ($signed(mem_q) < $signed(best_r));
  assign c_inc  = cnt_r + CW'(hit);

  // Sequencer: request decode, memory walks and result staging.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    lim_nxt    = lim_r;
    cnt_nxt    = cnt_r;
    best_nxt   = best_r;
    pend_v_nxt = pend_v_r;
    pend_w_nxt = pend_w_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    emit       = 1'b0;
    em         = '0;
    stop       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt  = in_ch.payload.func;
          pos_nxt = posx;
          val_nxt = in_ch.payload.value;
          res_nxt = '{status: ST_OK, data: '0, where: '0,
                      tally: fill_r[POS_W-1:0], last: 1'b1};
          state_nxt = S_FIN;
          case (in_ch.payload.func)
            F_NOP: begin
              state_nxt = S_IDLE;
            end
            F_CLEAR: begin
              fill_nxt = '0;
              res_nxt.tally = '0;
            end
            F_SIZE: begin
            end
            F_APPEND: begin
              if (fill_r >= CW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = fill_r[AW-1:0];
                mem_wd   = in_ch.payload.value;
                fill_nxt = fill_r + CW'(1);
                res_nxt.where = fill_nxt[POS_W-1:0];
                res_nxt.tally = fill_nxt[POS_W-1:0];
              end
            end
            F_INSERT: begin
              if (fill_r >= CW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else if (posx == '0 || posx > fill_r + CW'(1)) begin
                res_nxt.status = ST_BADPOS;
              end else begin
                idx_nxt   = fill_r;
                state_nxt = S_INS;
              end
            end
            default: begin
              if (fill_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                case (in_ch.payload.func)
                  F_READ, F_UPDATE, F_DELETE: begin
                    if (posx == '0 || posx > fill_r) begin
                      res_nxt.status = ST_BADPOS;
                    end else if (in_ch.payload.func == F_READ) begin
                      mem_re    = 1'b1;
                      mem_ra    = AW'(posx - CW'(1));
                      res_nxt.where = in_ch.payload.position;
                      state_nxt = S_RDP;
                    end else if (in_ch.payload.func == F_UPDATE) begin
                      mem_we = 1'b1;
                      mem_wa = AW'(posx - CW'(1));
                      mem_wd = in_ch.payload.value;
                      res_nxt.where = in_ch.payload.position;
                    end else begin
                      idx_nxt   = posx - CW'(1);
                      state_nxt = S_DEL;
                    end
                  end
                  F_SORT: begin
                    lim_nxt = fill_r - CW'(1);
                    if (fill_r != CW'(1)) begin
                      state_nxt = S_SRT0;
                    end
                  end
                  default: begin
                    idx_nxt    = '0;
                    cnt_nxt    = '0;
                    pend_v_nxt = 1'b0;
                    state_nxt  = S_SCR;
                  end
                endcase
              end
            end
          endcase
        end
      end

      // Single read: the element arrives in the cycle after the address.
      S_RDP: begin
        res_nxt.data = mem_q;
        state_nxt    = S_FIN;
      end

      // Insert: move elements up one place, top first, then drop the new value in.
      S_INS: begin
        if (idx_r < pos_r) begin
          mem_we   = 1'b1;
          mem_wa   = AW'(pos_r - CW'(1));
          mem_wd   = val_r;
          fill_nxt = fill_r + CW'(1);
          res_nxt.where = pos_r[POS_W-1:0];
          res_nxt.tally = fill_nxt[POS_W-1:0];
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = AW'(idx_r - CW'(1));
          state_nxt = S_INSW;
        end
      end
      S_INSW: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = mem_q;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_INS;
      end

      // Delete: move the elements above the hole down one place.
      S_DEL: begin
        if (idx_r + CW'(1) >= fill_r) begin
          fill_nxt = fill_r - CW'(1);
          res_nxt.where = pos_r[POS_W-1:0];
          res_nxt.tally = fill_nxt[POS_W-1:0];
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = AW'(idx_r + CW'(1));
          state_nxt = S_DELW;
        end
      end
      S_DELW: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = mem_q;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_DEL;
      end

      // Bubble sort: the larger element is carried up through each pass.
      S_SRT0: begin
        mem_re    = 1'b1;
        mem_ra    = '0;
        state_nxt = S_SRTC;
      end
      S_SRTC: begin
        best_nxt  = mem_q;
        idx_nxt   = '0;
        state_nxt = S_SRTR;
      end
      S_SRTR: begin
        mem_re    = 1'b1;
        mem_ra    = AW'(idx_r + CW'(1));
        state_nxt = S_SRTE;
      end
      S_SRTE: begin
        mem_we = 1'b1;
        mem_wa = idx_r[AW-1:0];
        if ($signed(best_r) > $signed(mem_q)) begin
          mem_wd = mem_q;
        end else begin
          mem_wd   = best_r;
          best_nxt = mem_q;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = (idx_nxt == lim_r) ? S_SRTX : S_SRTR;
      end
      S_SRTX: begin
        mem_we  = 1'b1;
        mem_wa  = lim_r[AW-1:0];
        mem_wd  = best_r;
        lim_nxt = lim_r - CW'(1);
        state_nxt = (lim_r == CW'(1)) ? S_FIN : S_SRT0;
      end

      // Scan: issue the read of the next element.
      S_SCR: begin
        mem_re = 1'b1;
        mem_ra = (op_r == F_REVERSE) ? AW'(fill_r - CW'(1) - idx_r) : idx_r[AW-1:0];
        state_nxt = S_SCE;
      end

      // Scan: evaluate the element that has just been read.
      S_SCE: begin
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SCR;
        case (op_r)
          F_CONTAINS: begin
            if (hit) begin
              res_nxt.where = idx_nxt[POS_W-1:0];
              state_nxt = S_FIN;
            end else if (at_end) begin
              res_nxt.status = ST_NOTFOUND;
              state_nxt = S_FIN;
            end
          end
          F_COUNT: begin
            cnt_nxt = c_inc;
            if (at_end) begin
              res_nxt.status = (c_inc != '0) ? ST_OK : ST_NOTFOUND;
              res_nxt.tally  = c_inc[POS_W-1:0];
              state_nxt = S_FIN;
            end
          end
          F_MAX, F_MIN: begin
            if (idx_r == '0 || better) begin
              best_nxt = mem_q;
            end
            if (at_end) begin
              res_nxt.data = best_nxt;
              state_nxt = S_FIN;
            end
          end
          F_POSNS: begin
            if (hit && pend_v_r && !can_emit) begin
              idx_nxt   = idx_r;
              state_nxt = S_SCE;
            end else begin
              if (hit) begin
                if (pend_v_r) begin
                  emit = 1'b1;
                  em   = '{status: ST_OK, data: val_r, where: pend_w_r,
                           tally: fill_r[POS_W-1:0], last: 1'b0};
                end
                pend_v_nxt = 1'b1;
                pend_w_nxt = idx_nxt[POS_W-1:0];
                cnt_nxt    = cnt_r + CW'(1);
              end
              stop = at_end || (cnt_nxt == CW'(MAX_RESULTS));
              if (stop) begin
                if (pend_v_nxt) begin
                  res_nxt.data  = val_r;
                  res_nxt.where = pend_w_nxt;
                end else begin
                  res_nxt.status = ST_NOTFOUND;
                end
                state_nxt = S_FIN;
              end
            end
          end
          F_LIST, F_REVERSE: begin
            if (!can_emit) begin
              idx_nxt   = idx_r;
              state_nxt = S_SCE;
            end else begin
              emit = 1'b1;
              em   = '{status: ST_OK, data: mem_q,
                       where: (op_r == F_REVERSE) ? POS_W'(fill_r - idx_r)
                                                  : idx_nxt[POS_W-1:0],
                       tally: fill_r[POS_W-1:0], last: (idx_nxt == list_n)};
              if (idx_nxt == list_n) begin
                state_nxt = S_IDLE;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Final result of the request.
      S_FIN: begin
        if (can_emit) begin
          emit      = 1'b1;
          em        = res_r;
          em.last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    lim_r    <= lim_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    pend_w_r <= pend_w_nxt;
    res_r    <= res_nxt;
    if (emit) begin
      out_r <= em;
    end
  end

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> can_emit) else $error("result overwritten");

  // The fill count never exceeds the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY)) else $error("fill beyond capacity");

  // The sequencer never reads and writes the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra)) else $error("read/write clash");

  // Requests are only taken while no result is being produced.
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !emit) else $error("accept during emission");
endmodule
